>>> hw/rtl/siamd_pkg.sv
// ----------------------------------------------------------------------------
// siamd_pkg
// Shared operation codes and pipeline control type for the signed ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package siamd_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_NEG = 4'd2,
    OP_MUL = 4'd3,
    OP_DIV = 4'd4,
    OP_MOD = 4'd5,
    OP_SHL = 4'd6,
    OP_SAR = 4'd7,
    OP_AND = 4'd8,
    OP_OR  = 4'd9,
    OP_XOR = 4'd10,
    OP_NOT = 4'd11,
    OP_CMP = 4'd12
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
    logic less;
    logic equal;
    logic div_zero;
    logic neg_a;
    logic neg_b;
  } ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/siamd_front.sv
// ----------------------------------------------------------------------------
// siamd_front
// Entry stage: simple operations, flags, magnitudes and multiplier partials.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module siamd_front #(
  parameter int WIDTH = 64,
  parameter int LOW   = (WIDTH + 1) / 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [3:0]            req_type,
  input  wire logic [WIDTH-1:0]      a,
  input  wire logic [WIDTH-1:0]      b,
  input  wire logic [6:0]            shift_amount,
  output siamd_pkg::ctl_t            ctl,
  output logic      [WIDTH-1:0]      res,
  output logic      [WIDTH-1:0]      mag_a,
  output logic      [WIDTH-1:0]      mag_b,
  output logic      [WIDTH-1:0]      prod_lo,
  output logic      [WIDTH-LOW-1:0]  prod_cross
);

  localparam int HIGH = WIDTH - LOW;

  siamd_pkg::op_t       op;
  logic [WIDTH-1:0]     res_next;
  logic                 neg_a;
  logic                 neg_b;
  logic                 long_shift;
  logic [2*LOW-1:0]     p_ll;
  logic [HIGH-1:0]      p_lh;
  logic [HIGH-1:0]      p_hl;

  assign op         = siamd_pkg::op_t'(req_type);
  assign neg_a      = a[WIDTH-1];
  assign neg_b      = b[WIDTH-1];
  assign long_shift = shift_amount >= 7'(WIDTH);

  // low product full, cross products only where they land below WIDTH
  assign p_ll = {{LOW{1'b0}}, a[LOW-1:0]} * {{LOW{1'b0}}, b[LOW-1:0]};
  assign p_lh = HIGH'(a[LOW-1:0]) * b[WIDTH-1:LOW];
  assign p_hl = a[WIDTH-1:LOW] * HIGH'(b[LOW-1:0]);

  always_comb begin
    res_next = '0;
    case (op)
      siamd_pkg::OP_ADD: res_next = a + b;
      siamd_pkg::OP_SUB: res_next = a - b;
      siamd_pkg::OP_NEG: res_next = '0 - a;
      siamd_pkg::OP_SHL: res_next = long_shift ? '0 : (a << shift_amount);
      siamd_pkg::OP_SAR: res_next = long_shift ? {WIDTH{neg_a}}
                                               : WIDTH'($signed(a) >>> shift_amount);
      siamd_pkg::OP_AND: res_next = a & b;
      siamd_pkg::OP_OR:  res_next = a | b;
      siamd_pkg::OP_XOR: res_next = a ^ b;
      siamd_pkg::OP_NOT: res_next = ~a;
      default:           res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= start;
    end
    ctl.op       <= op;
    ctl.less     <= $signed(a) < $signed(b);
    ctl.equal    <= a == b;
    ctl.div_zero <= (op == siamd_pkg::OP_DIV || op == siamd_pkg::OP_MOD) && (b == '0);
    ctl.neg_a    <= neg_a;
    ctl.neg_b    <= neg_b;
    res          <= res_next;
    mag_a        <= neg_a ? ('0 - a) : a;
    mag_b        <= neg_b ? ('0 - b) : b;
    prod_lo      <= p_ll[WIDTH-1:0];
    prod_cross   <= p_lh + p_hl;
  end

endmodule

`default_nettype wire

>>> hw/rtl/siamd_div_stage.sv
// ----------------------------------------------------------------------------
// siamd_div_stage
// One restoring division step per stage, carrying the other lanes along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module siamd_div_stage #(
  parameter int WIDTH = 64,
  parameter int SIDE  = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire siamd_pkg::ctl_t   ctl_in,
  input  wire logic [WIDTH-1:0]  rem_in,
  input  wire logic [WIDTH-1:0]  quo_in,
  input  wire logic [WIDTH-1:0]  dsr_in,
  input  wire logic [SIDE-1:0]   side_in,
  output siamd_pkg::ctl_t        ctl_out,
  output logic      [WIDTH-1:0]  rem_out,
  output logic      [WIDTH-1:0]  quo_out,
  output logic      [WIDTH-1:0]  dsr_out,
  output logic      [SIDE-1:0]   side_out
);

  logic [WIDTH:0] shifted;
  logic [WIDTH:0] diff;
  logic           fits;

  assign shifted = {rem_in, quo_in[WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr_in};
  assign fits    = !diff[WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.op       <= ctl_in.op;
    ctl_out.less     <= ctl_in.less;
    ctl_out.equal    <= ctl_in.equal;
    ctl_out.div_zero <= ctl_in.div_zero;
    ctl_out.neg_a    <= ctl_in.neg_a;
    ctl_out.neg_b    <= ctl_in.neg_b;
    rem_out          <= fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    quo_out          <= {quo_in[WIDTH-2:0], fits};
    dsr_out          <= dsr_in;
    side_out         <= side_in;
  end

endmodule

`default_nettype wire

>>> hw/rtl/siamd_back.sv
// ----------------------------------------------------------------------------
// siamd_back
// Final stage: product sum, quotient and remainder signs, result select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module siamd_back #(
  parameter int WIDTH = 64,
  parameter int LOW   = (WIDTH + 1) / 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire siamd_pkg::ctl_t       ctl,
  input  wire logic [WIDTH-1:0]      res,
  input  wire logic [WIDTH-1:0]      quo,
  input  wire logic [WIDTH-1:0]      rem,
  input  wire logic [WIDTH-1:0]      prod_lo,
  input  wire logic [WIDTH-LOW-1:0]  prod_cross,
  output logic                       done,
  output logic      [63:0]           result_value,
  output logic                       is_less,
  output logic                       is_equal,
  output logic                       divide_by_zero
);

  logic [WIDTH-1:0] sel;

  always_comb begin
    sel = res;
    case (ctl.op)
      siamd_pkg::OP_MUL: sel = prod_lo + {prod_cross, {LOW{1'b0}}};
      siamd_pkg::OP_DIV: sel = (ctl.neg_a ^ ctl.neg_b) ? ('0 - quo) : quo;
      siamd_pkg::OP_MOD: sel = ctl.neg_a ? ('0 - rem) : rem;
      default:           sel = res;
    endcase
    if (ctl.div_zero) begin
      sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
    result_value   <= 64'($signed(sel));
    is_less        <= ctl.less;
    is_equal       <= ctl.equal;
    divide_by_zero <= ctl.div_zero;
  end

endmodule

`default_nettype wire

>>> hw/rtl/signed_integer_alu_mul_div_unit.sv
// ----------------------------------------------------------------------------
// signed_integer_alu_mul_div_unit
// Pipelined WIDTH-bit two's-complement ALU with multiply and divide.
// ----------------------------------------------------------------------------
// every operation passes through one front register, WIDTH one-bit divider stages
// and one output register before done rises
// throughput: one transaction per cycle, every stage takes a new one each cycle
// busy is never raised; the receiver cannot stall so no backpressure exists
// synchronous reset clears all stage valid bits, nothing else is reset
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_alu_mul_div_unit #(
  parameter int WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  req_type,
  input  wire logic [63:0] operand_a,
  input  wire logic [63:0] operand_b,
  input  wire logic [6:0]  shift_amount,
  output logic             done,
  output logic [63:0]      result_value,
  output logic             is_less,
  output logic             is_equal,
  output logic             divide_by_zero
);

  localparam int LOW  = (WIDTH + 1) / 2;
  localparam int SIDE = 2 * WIDTH + (WIDTH - LOW);

  siamd_pkg::ctl_t        ctl  [WIDTH+1];
  logic [WIDTH-1:0]       rem  [WIDTH+1];
  logic [WIDTH-1:0]       quo  [WIDTH+1];
  logic [WIDTH-1:0]       dsr  [WIDTH+1];
  logic [SIDE-1:0]        side [WIDTH+1];
  logic [WIDTH-1:0]       f_res;
  logic [WIDTH-1:0]       f_lo;
  logic [WIDTH-LOW-1:0]   f_cross;

  assign busy = 1'b0;

  siamd_front #(.WIDTH(WIDTH), .LOW(LOW)) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req_type     (req_type),
    .a            (operand_a[WIDTH-1:0]),
    .b            (operand_b[WIDTH-1:0]),
    .shift_amount (shift_amount),
    .ctl          (ctl[0]),
    .res          (f_res),
    .mag_a        (quo[0]),
    .mag_b        (dsr[0]),
    .prod_lo      (f_lo),
    .prod_cross   (f_cross)
  );

  assign rem[0]  = '0;
  assign side[0] = {f_res, f_lo, f_cross};

  for (genvar i = 0; i < WIDTH; i++) begin : g_div
    siamd_div_stage #(.WIDTH(WIDTH), .SIDE(SIDE)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl[i]),
      .rem_in   (rem[i]),
      .quo_in   (quo[i]),
      .dsr_in   (dsr[i]),
      .side_in  (side[i]),
      .ctl_out  (ctl[i+1]),
      .rem_out  (rem[i+1]),
      .quo_out  (quo[i+1]),
      .dsr_out  (dsr[i+1]),
      .side_out (side[i+1])
    );
  end

  siamd_back #(.WIDTH(WIDTH), .LOW(LOW)) u_back (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl[WIDTH]),
    .res            (side[WIDTH][SIDE-1 -: WIDTH]),
    .quo            (quo[WIDTH]),
    .rem            (rem[WIDTH]),
    .prod_lo        (side[WIDTH][WIDTH-LOW +: WIDTH]),
    .prod_cross     (side[WIDTH][WIDTH-LOW-1:0]),
    .done           (done),
    .result_value   (result_value),
    .is_less        (is_less),
    .is_equal       (is_equal),
    .divide_by_zero (divide_by_zero)
  );

  a_enter: assert property (@(posedge clk) disable iff (rst) start |=> ctl[0].valid)
    else $error("accepted transaction did not enter the pipeline");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (result_value == 64'd0))
    else $error("divide by zero with nonzero result");
  a_flags: assert property (@(posedge clk) disable iff (rst) (done && is_equal) |-> !is_less)
    else $error("equal and less both set");
  a_last: assert property (@(posedge clk) disable iff (rst) ctl[WIDTH].valid |=> done)
    else $error("last divider stage valid lost before output");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed ALU: random and corner-case transactions
// with bursty issue, results compared in order against a built-in predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int WIDTH = 64;
  localparam int LATENCY = WIDTH + 2;

  typedef struct {
    logic [63:0] value;
    logic        less;
    logic        equal;
    logic        dz;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending[$];
    int          mismatches;
    int          orphans;

    function alu_result_t compute(logic [3:0] op, logic [63:0] a, logic [63:0] b,
                                  logic [6:0] sh);
      alu_result_t res;
      logic [63:0] ma, mb, q, rm;
      logic signed [63:0] sr;
      res.value = '0;
      res.dz    = 1'b0;
      res.less  = $signed(a) < $signed(b);
      res.equal = (a == b);
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      sr = $signed(a) >>> sh;
      case (op)
        siamd_pkg::OP_ADD: res.value = a + b;
        siamd_pkg::OP_SUB: res.value = a - b;
        siamd_pkg::OP_NEG: res.value = -a;
        siamd_pkg::OP_MUL: res.value = a * b;
        siamd_pkg::OP_DIV, siamd_pkg::OP_MOD: begin
          if (b == '0) begin
            res.dz = 1'b1;
          end else begin
            q  = ma / mb;
            rm = ma % mb;
            if (op == siamd_pkg::OP_DIV) res.value = (a[63] != b[63]) ? -q : q;
            else res.value = a[63] ? -rm : rm;
          end
        end
        siamd_pkg::OP_SHL: res.value = (sh >= WIDTH) ? '0 : a << sh;
        siamd_pkg::OP_SAR: res.value = (sh >= WIDTH) ? {64{a[63]}} : sr;
        siamd_pkg::OP_AND: res.value = a & b;
        siamd_pkg::OP_OR:  res.value = a | b;
        siamd_pkg::OP_XOR: res.value = a ^ b;
        siamd_pkg::OP_NOT: res.value = ~a;
        default: res.value = '0;
      endcase
      return res;
    endfunction

    function void note_request(logic [3:0] op, logic [63:0] a, logic [63:0] b,
                               logic [6:0] sh);
      pending.insert(pending.size(), compute(op, a, b, sh));
    endfunction

    function void check_result(alu_result_t got);
      alu_result_t want;
      if (pending.size() == 0) begin
        orphans++;
        if (mismatches + orphans <= 10) $display("unexpected result %h", got.value);
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value || got.less !== want.less ||
          got.equal !== want.equal || got.dz !== want.dz) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h l%b e%b z%b, got %h l%b e%b z%b",
                   want.value, want.less, want.equal, want.dz,
                   got.value, got.less, got.equal, got.dz);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  req_type = '0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic [6:0]  shift_amount = '0;
  logic        done;
  logic [63:0] result_value;
  logic        is_less, is_equal, divide_by_zero;

  alu_scoreboard board = new();

  signed_integer_alu_mul_div_unit #(.WIDTH(WIDTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .operand_a(operand_a), .operand_b(operand_b), .shift_amount(shift_amount),
    .done(done), .result_value(result_value), .is_less(is_less),
    .is_equal(is_equal), .divide_by_zero(divide_by_zero)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    alu_result_t got;
    if (!rst && done) begin
      got.value = result_value;
      got.less  = is_less;
      got.equal = is_equal;
      got.dz    = divide_by_zero;
      board.check_result(got);
    end
  end

  int burst_left = 0;

  // one transaction; start stays high across back-to-back items
  task automatic issue(logic [3:0] op, logic [63:0] a, logic [63:0] b, logic [6:0] sh);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start        <= 1'b1;
    req_type     <= op;
    operand_a    <= a;
    operand_b    <= b;
    shift_amount <= sh;
    do @(posedge clk); while (busy);
    board.note_request(op, a, b, sh);
    @(negedge clk);
  endtask

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return '0;
      3: return '1;
      4: return 64'(int'($urandom_range(0, 20)) - 10);
      5: return {32'h0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  initial begin
    int waited;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed corners
    issue(siamd_pkg::OP_ADD, MOST_POS, 64'd1, 7'd0);
    issue(siamd_pkg::OP_SUB, MOST_NEG, 64'd1, 7'd0);
    issue(siamd_pkg::OP_NEG, MOST_NEG, '0, 7'd0);
    issue(siamd_pkg::OP_MUL, MOST_NEG, '1, 7'd0);
    issue(siamd_pkg::OP_MUL, -64'sd7, 64'd3, 7'd0);
    issue(siamd_pkg::OP_DIV, MOST_NEG, '1, 7'd0);
    issue(siamd_pkg::OP_MOD, MOST_NEG, '1, 7'd0);
    issue(siamd_pkg::OP_DIV, -64'sd7, 64'd2, 7'd0);
    issue(siamd_pkg::OP_MOD, -64'sd7, 64'd2, 7'd0);
    issue(siamd_pkg::OP_DIV, 64'd5, '0, 7'd0);
    issue(siamd_pkg::OP_MOD, MOST_NEG, '0, 7'd0);
    issue(siamd_pkg::OP_SHL, '1, '0, 7'd63);
    issue(siamd_pkg::OP_SHL, '1, '0, 7'd64);
    issue(siamd_pkg::OP_SHL, '1, '0, 7'd127);
    issue(siamd_pkg::OP_SAR, MOST_NEG, '0, 7'd0);
    issue(siamd_pkg::OP_SAR, MOST_NEG, '0, 7'd63);
    issue(siamd_pkg::OP_SAR, MOST_NEG, '0, 7'd100);
    issue(siamd_pkg::OP_SAR, MOST_POS, '0, 7'd64);
    issue(siamd_pkg::OP_AND, '1, MOST_NEG, 7'd0);
    issue(siamd_pkg::OP_OR, '0, MOST_POS, 7'd0);
    issue(siamd_pkg::OP_XOR, '1, MOST_POS, 7'd0);
    issue(siamd_pkg::OP_NOT, '0, '0, 7'd0);
    issue(siamd_pkg::OP_CMP, MOST_NEG, MOST_POS, 7'd0);
    issue(siamd_pkg::OP_CMP, MOST_POS, MOST_POS, 7'd0);
    issue(4'd15, '1, '0, 7'd5);
    for (int n = 0; n < 1050; n++)
      issue(4'($urandom_range(0, 15)), pick_operand(), pick_operand(),
            7'($urandom_range(0, 127)));
    start <= 1'b0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 10 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY) @(posedge clk);
    if (board.pending.size() == 0 && board.mismatches == 0 && board.orphans == 0)
      $display("signed_integer_alu_mul_div_unit verification clean");
    else
      $display("signed_integer_alu_mul_div_unit verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("signed_integer_alu_mul_div_unit verification failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/siamd_pkg.sv
hw/rtl/siamd_front.sv
hw/rtl/siamd_div_stage.sv
hw/rtl/siamd_back.sv
hw/rtl/signed_integer_alu_mul_div_unit.sv
tb/tb_top.sv
